@@ rtl/wbps_pkg.sv @@
// shared constants and types for the wildcard byte pattern scan unit
`default_nettype none

package wbps_pkg;

   // widths fixed by the item and register fields
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 5;
   localparam int CARE_W     = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   // signature storage in the registers and the longest usable signature
   localparam int REG_PATTERN_BYTES = 16;
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int LEN_LIMIT  = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                               MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
   // window cells hold the bytes before the current one
   localparam int CELL_COUNT = (LEN_LIMIT > 1) ? (LEN_LIMIT - 1) : 1;
   // compare slots: slot 0 is the current byte, slot k+1 is window cell k
   localparam int SLOT_COUNT = CELL_COUNT + 1;

   // register reset values
   localparam logic [CARE_W-1:0] CARE_RESET = {CARE_W{1'b1}};
   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(1);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = CSR_IDX_W'(4);

   // expected byte for one window position, already aligned to the length
   typedef struct packed {
      logic [BYTE_W-1:0] sig;
      logic              care;
   } pattern_slot_type;

endpackage

`default_nettype wire

@@ rtl/wbps_align.sv @@
// aligns the signature and care mask to window positions for the current length
`default_nettype none

module wbps_align
   import wbps_pkg::*;
(
   input  wire logic [CSR_DATA_W-1:0] pattern_low,
   input  wire logic [CSR_DATA_W-1:0] pattern_high,
   input  wire logic [CARE_W-1:0]     care_mask,
   input  wire logic [LEN_W-1:0]      pattern_length,
   output pattern_slot_type           slots [SLOT_COUNT],
   output logic [LEN_W-1:0]           len_eff
);

   logic [BYTE_W-1:0] sig_bytes [REG_PATTERN_BYTES];

   // zero length acts as one, long lengths clamp to the limit
   always_comb begin
      if (pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (pattern_length > LEN_W'(LEN_LIMIT)) begin
         len_eff = LEN_W'(LEN_LIMIT);
      end else begin
         len_eff = pattern_length;
      end
   end

   // unpack signature bytes, byte 0 in the low bits of the low word
   always_comb begin
      for (int i = 0; i < REG_PATTERN_BYTES; i++) begin
         if (i < 8) begin
            sig_bytes[i] = pattern_low[i*BYTE_W +: BYTE_W];
         end else begin
            sig_bytes[i] = pattern_high[(i-8)*BYTE_W +: BYTE_W];
         end
      end
   end

   // the byte 'b' positions back pairs with signature byte len - 1 - b
   always_comb begin
      logic [LEN_W-1:0] idx;
      idx = '0;
      for (int b = 0; b < SLOT_COUNT; b++) begin
         idx = len_eff - LEN_W'(b) - LEN_W'(1);
         slots[b].sig  = sig_bytes[idx[3:0]];
         slots[b].care = (LEN_W'(b) < len_eff) && care_mask[idx[3:0]];
      end
   end

endmodule

`default_nettype wire

@@ rtl/wbps_cell.sv @@
// one window cell: holds a past byte, passes it on and checks it against its slot
`default_nettype none

module wbps_cell
   import wbps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire logic [BYTE_W-1:0] prev_byte,
   input  wire pattern_slot_type  slot,
   output logic [BYTE_W-1:0]      held_byte,
   output logic                   mismatch
);

   logic [BYTE_W-1:0] stored_ff;
   logic [BYTE_W-1:0] stored_in;

   // take the neighbour's byte on every accepted item
   assign stored_in = shift_en ? prev_byte : stored_ff;

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
   end

   assign held_byte = stored_ff;
   assign mismatch  = slot.care && (stored_ff != slot.sig);

endmodule

`default_nettype wire

@@ rtl/wildcard_byte_pattern_scan_unit.sv @@
// Wildcard byte signature scan over a byte stream, one byte per item.
// Result items go to the output register, via the skid stage while that one stalls.
// Throughput: one byte per cycle while req_stall is low, set by the chain of window
// cells that compare every window position in parallel against the aligned signature.
// Reset (synchronous, active high) clears the offset, the done latch, the output
// and skid stages and loads the register reset values; window bytes are not cleared.
`default_nettype none

module wildcard_byte_pattern_scan_unit
   import wbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte items
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_mem_byte,
   input  wire logic                  req_first_byte,
   input  wire logic                  req_last_byte,
   // result items
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_found,
   output logic [ADDR_W-1:0]          rsp_match_address,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [ADDR_W-1:0]     base_ff;
   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [CARE_W-1:0]     care_ff;
   logic [LEN_W-1:0]      len_ff;

   // scan state
   logic [ADDR_W-1:0] offset_ff;
   logic [ADDR_W-1:0] offset_in;
   logic              done_ff;
   logic              done_in;

   // output register and skid stage
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_found_ff;
   logic              out_found_in;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [ADDR_W-1:0] out_addr_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic              skid_found_ff;
   logic              skid_found_in;
   logic [ADDR_W-1:0] skid_addr_ff;
   logic [ADDR_W-1:0] skid_addr_in;

   pattern_slot_type  slots [SLOT_COUNT];
   logic [LEN_W-1:0]  len_eff;
   logic [BYTE_W-1:0] cell_bytes [CELL_COUNT];
   logic [CELL_COUNT-1:0] cell_mismatch;

   logic              accept;
   logic              out_take;
   logic [ADDR_W-1:0] pos;
   logic              done_eff;
   logic              cur_mismatch;
   logic [ADDR_W:0]   start_diff;
   logic              enough_bytes;
   logic              match;
   logic              produce;
   logic [ADDR_W-1:0] res_addr;

   // register write port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= CARE_RESET;
         len_ff      <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_ff     <= csr_wdata[ADDR_W-1:0];
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_CARE_MASK:    care_ff     <= csr_wdata[CARE_W-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // signature aligned to window positions
   wbps_align u_align (
      .pattern_low    (pat_low_ff),
      .pattern_high   (pat_high_ff),
      .care_mask      (care_ff),
      .pattern_length (len_ff),
      .slots          (slots),
      .len_eff        (len_eff)
   );

   assign accept = req_valid && !req_stall;

   // chain of window cells, newest byte enters cell 0
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      wbps_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .prev_byte ((k == 0) ? req_mem_byte : cell_bytes[(k == 0) ? 0 : k-1]),
         .slot      (slots[k+1]),
         .held_byte (cell_bytes[k]),
         .mismatch  (cell_mismatch[k])
      );
   end

   // current byte against slot 0
   assign cur_mismatch = slots[0].care && (req_mem_byte != slots[0].sig);

   // a new scan restarts the offset and the done latch
   assign pos      = req_first_byte ? '0 : offset_ff;
   assign done_eff = req_first_byte ? 1'b0 : done_ff;

   // match start offset; the borrow tells whether enough bytes were seen
   assign start_diff   = {1'b0, pos} - (ADDR_W+1)'(len_eff - LEN_W'(1));
   assign enough_bytes = !start_diff[ADDR_W];
   assign match        = enough_bytes && !cur_mismatch && !(|cell_mismatch);
   assign produce      = accept && !done_eff && (match || req_last_byte);
   assign res_addr     = match ? (base_ff + start_diff[ADDR_W-1:0]) : '0;

   // offset saturates at its maximum
   always_comb begin
      offset_in = offset_ff;
      done_in   = done_ff;
      if (accept) begin
         offset_in = (pos != {ADDR_W{1'b1}}) ? (pos + ADDR_W'(1)) : pos;
         done_in   = done_eff || produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         done_ff   <= done_in;
      end
   end

   // output register with a skid stage behind it
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_addr_in   = out_addr_ff;
      skid_valid_in = skid_valid_ff;
      skid_found_in = skid_found_ff;
      skid_addr_in  = skid_addr_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_found_in  = skid_found_ff;
            out_addr_in   = skid_addr_ff;
            skid_valid_in = produce;
            skid_found_in = match;
            skid_addr_in  = res_addr;
         end else begin
            out_valid_in = produce;
            out_found_in = match;
            out_addr_in  = res_addr;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_found_in = match;
         skid_addr_in  = res_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff  <= out_found_in;
      out_addr_ff   <= out_addr_in;
      skid_found_ff <= skid_found_in;
      skid_addr_ff  <= skid_addr_in;
   end

   // stall new bytes only while the skid stage holds an item
   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_match_address = out_addr_ff;

endmodule

`default_nettype wire

@@ rtl/wbps_checker.sv @@
// port-level checks for the scan unit, bound to the top level
`default_nettype none

module wbps_checker
   import wbps_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_found,
   input wire logic [ADDR_W-1:0] rsp_match_address
);

   // no result item straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item right after reset");

   // a not-found item carries address zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_address == '0))
      else $error("not-found item with nonzero address");

   // bytes stall only while a result item is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("byte stall without a waiting result item");

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_match_address)))
      else $error("stalled result item changed");

endmodule

bind wildcard_byte_pattern_scan_unit wbps_checker u_wbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_match_address (rsp_match_address)
);

`default_nettype wire

@@ tb/wbps_scan_checker.sv @@
// checker for the pattern scan unit: predicts scan results from accepted items and compares them
`timescale 1ns / 100ps

module wbps_scan_checker
   import wbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [BYTE_W-1:0]     req_mem_byte,
   input  wire logic                  req_first_byte,
   input  wire logic                  req_last_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic                  rsp_found,
   input  wire logic [ADDR_W-1:0]     rsp_match_address,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         pending_results,
   output int                         failures
);

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] address;
   } scan_outcome_type;

   // results predicted but not yet seen, oldest first
   scan_outcome_type outcomes_due [$];

   // shadow registers
   logic [ADDR_W-1:0]     base_address;
   logic [CSR_DATA_W-1:0] pattern_low;
   logic [CSR_DATA_W-1:0] pattern_high;
   logic [CARE_W-1:0]     care_mask;
   logic [LEN_W-1:0]      pattern_len;

   // scan state: earlier bytes newest first, offset of the next byte, done latch
   logic [BYTE_W-1:0]     history [CELL_COUNT];
   logic [ADDR_W-1:0]     byte_offset;
   logic                  scan_done;
   int                    fail_total = 0;

   // length in use: zero counts as one, long values clamp to the limit
   function automatic int used_length();
      int n;
      n = int'(pattern_len);
      if (n == 0) n = 1;
      if (n > LEN_LIMIT) n = LEN_LIMIT;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] signature_byte(int i);
      if (i < 8) return pattern_low[i*BYTE_W +: BYTE_W];
      return pattern_high[(i-8)*BYTE_W +: BYTE_W];
   endfunction

   // does the signature end at the current byte
   function automatic bit signature_ends_here(logic [BYTE_W-1:0] cur, int len);
      logic [BYTE_W-1:0] seen;
      int back;
      for (int i = 0; i < len; i++) begin
         if (care_mask[i]) begin
            back = len - 1 - i;
            seen = (back == 0) ? cur : history[back - 1];
            if (seen != signature_byte(i)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // advance the scan by one byte and note any result it causes
   task automatic absorb_byte(logic [BYTE_W-1:0] cur, logic first, logic last);
      int len;
      scan_outcome_type outcome;
      len = used_length();
      if (first) begin
         byte_offset = '0;
         scan_done = 1'b0;
      end
      if (!scan_done) begin
         // a match needs all its bytes inside the current scan
         if (byte_offset >= ADDR_W'(len - 1) && signature_ends_here(cur, len)) begin
            outcome.found = 1'b1;
            outcome.address = base_address + byte_offset - ADDR_W'(len - 1);
            outcomes_due.push_back(outcome);
            scan_done = 1'b1;
         end else if (last) begin
            outcome = '0;
            outcomes_due.push_back(outcome);
            scan_done = 1'b1;
         end
      end
      for (int k = CELL_COUNT - 1; k > 0; k--) history[k] = history[k - 1];
      history[0] = cur;
      // offset saturates
      if (byte_offset != '1) byte_offset++;
   endtask

   task automatic compare_result();
      scan_outcome_type want;
      if (outcomes_due.size() == 0) begin
         $error("result item with none expected: found %0d, match_address 0x%08h",
                rsp_found, rsp_match_address);
         fail_total++;
      end else begin
         want = outcomes_due.pop_front();
         if (rsp_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_found);
            fail_total++;
         end
         if (rsp_match_address !== want.address) begin
            $error("match_address: expected 0x%08h, got 0x%08h",
                   want.address, rsp_match_address);
            fail_total++;
         end
      end
   endtask

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         base_address = '0;
         pattern_low  = '0;
         pattern_high = '0;
         care_mask    = CARE_RESET;
         pattern_len  = LEN_RESET;
         byte_offset  = '0;
         scan_done    = 1'b0;
         for (int k = 0; k < CELL_COUNT; k++) history[k] = '0;
         outcomes_due.delete();
      end else begin
         // results first: a result never belongs to the item taken at the same edge
         if (rsp_valid && !rsp_stall) compare_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_ADDRESS: base_address = csr_wdata[ADDR_W-1:0];
               CSR_PATTERN_LOW:  pattern_low  = csr_wdata;
               CSR_PATTERN_HIGH: pattern_high = csr_wdata;
               CSR_CARE_MASK:    care_mask    = csr_wdata[CARE_W-1:0];
               CSR_PATTERN_LEN:  pattern_len  = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_byte(req_mem_byte, req_first_byte, req_last_byte);
      end
      pending_results <= outcomes_due.size();
      failures <= fail_total;
   end

endmodule

@@ tb/testbench.sv @@
// testbench top for the pattern scan unit: clock, reset, byte and register stimulus, verdict
`timescale 1ns / 100ps

module testbench
   import wbps_pkg::*;
();

   localparam int ITEM_TARGET = 1300;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_mem_byte = '0;
   logic                  req_first_byte = 1'b0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_found;
   logic [ADDR_W-1:0]     rsp_match_address;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int pending_results;
   int failures;
   int bytes_sent = 0;
   int cycle_count = 0;
   // no idling on either side while set
   bit calm = 1'b0;

   // signature as last programmed, used to plant matches
   logic [CSR_DATA_W-1:0] sig_low = '0;
   logic [CSR_DATA_W-1:0] sig_high = '0;
   logic [CARE_W-1:0]     sig_care = CARE_RESET;
   int                    sig_len = 1;

   wildcard_byte_pattern_scan_unit dut (.*);
   wbps_scan_checker scan_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[wildcard_byte_pattern_scan_unit] ERROR");
         $finish;
      end
   end

   // result side: random stall before each result item
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 8);
         rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic logic [BYTE_W-1:0] pattern_byte(int i);
      if (i < 8) return sig_low[i*BYTE_W +: BYTE_W];
      return sig_high[(i-8)*BYTE_W +: BYTE_W];
   endfunction

   // half the filler bytes come from the signature so that chance matches occur
   function automatic logic [BYTE_W-1:0] pick_byte();
      if ($urandom_range(0, 1) == 0) return BYTE_W'($urandom_range(0, 255));
      return pattern_byte($urandom_range(0, sig_len - 1));
   endfunction

   task automatic send_byte(logic [BYTE_W-1:0] value, logic first, logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mem_byte   <= value;
      req_first_byte <= first;
      req_last_byte  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_signature(logic [ADDR_W-1:0] base, logic [CSR_DATA_W-1:0] low,
                                    logic [CSR_DATA_W-1:0] high, logic [CARE_W-1:0] care,
                                    logic [LEN_W-1:0] len);
      write_reg(CSR_BASE_ADDRESS, CSR_DATA_W'(base));
      write_reg(CSR_PATTERN_LOW, low);
      write_reg(CSR_PATTERN_HIGH, high);
      write_reg(CSR_CARE_MASK, CSR_DATA_W'(care));
      write_reg(CSR_PATTERN_LEN, CSR_DATA_W'(len));
      csr_valid <= 1'b0;
      sig_low  = low;
      sig_high = high;
      sig_care = care;
      sig_len  = (len == 0) ? 1 : (int'(len) > LEN_LIMIT) ? LEN_LIMIT : int'(len);
   endtask

   // sender holds off until every expected result is out, then a short tail
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // one range: often with a planted signature, sometimes spoilt or malformed
   task automatic run_scan();
      int n;
      int plant;
      int spoil;
      int j;
      bit hit;
      bit no_first;
      bit no_last;
      logic [BYTE_W-1:0] b;
      logic first;
      hit      = ($urandom_range(0, 9) < 6);
      n        = hit ? sig_len + $urandom_range(0, 12) : $urandom_range(1, 24);
      plant    = hit ? $urandom_range(0, n - sig_len) : -1;
      spoil    = (hit && $urandom_range(0, 4) == 0) ? $urandom_range(0, sig_len - 1) : -1;
      no_first = ($urandom_range(0, 9) == 0);
      no_last  = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < n; k++) begin
         j = k - plant;
         if (plant >= 0 && j >= 0 && j < sig_len) begin
            b = sig_care[j] ? pattern_byte(j) : BYTE_W'($urandom_range(0, 255));
            if (j == spoil) b = b ^ (BYTE_W'(1) << $urandom_range(0, BYTE_W - 1));
         end else begin
            b = pick_byte();
         end
         // occasional restart in mid range
         first = (k == 0 && !no_first) || ($urandom_range(0, 49) == 0);
         send_byte(b, first, (k == n - 1) && !no_last);
      end
   endtask

   initial begin
      int phase;
      int random_start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset signature: one zero byte, must match
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);

      // overlapping candidate, match on the last byte, address wraps
      drain();
      program_signature(32'hFFFF_FFFF, 64'h0000_0000_0042_4141, '0, '1, 5'd3);
      send_byte(8'h41, 1'b1, 1'b0);
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h42, 1'b0, 1'b1);
      // short history: earlier scan's bytes must not complete a match
      send_byte(8'h41, 1'b1, 1'b0);
      send_byte(8'h41, 1'b0, 1'b1);
      send_byte(8'h42, 1'b1, 1'b1);
      // silent after a result until a new scan starts
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h42, 1'b0, 1'b1);

      // all wildcards
      drain();
      program_signature(32'h0, '1, '1, '0, 5'd4);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h22, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b0);
      send_byte(8'h44, 1'b0, 1'b1);

      // random phases, each with its own signature
      random_start = bytes_sent;
      phase = 0;
      while (bytes_sent - random_start < ITEM_TARGET) begin
         drain();
         case (phase)
            0: begin
               program_signature(32'hFFFF_FFFF, '1, '1, '1, 5'd16);
            end
            1: begin
               program_signature(32'h0, {$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd31);
            end
            2: begin
               program_signature($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                                 CARE_W'($urandom), 5'd0);
            end
            3: begin
               program_signature(32'hFFFF_FFF0, '0, '0, '1, 5'd17);
            end
            default: begin
               program_signature(
                  ($urandom_range(0, 3) == 0) ? 32'h0 :
                  ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ADDR_W'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom},
                  ($urandom_range(0, 3) == 0) ? CARE_W'('1) :
                  ($urandom_range(0, 3) == 0) ? CARE_W'(0) : CARE_W'($urandom),
                  ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 31)) :
                                                LEN_W'($urandom_range(1, LEN_LIMIT)));
            end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         phase++;
         random_start = random_start;
         while (bytes_sent - random_start < ITEM_TARGET &&
                bytes_sent < random_start + phase * 110) run_scan();
      end

      calm = 1'b0;
      drain();
      if (failures == 0) begin
         $display("[wildcard_byte_pattern_scan_unit] OK");
      end else begin
         $display("[wildcard_byte_pattern_scan_unit] ERROR");
      end
      $finish;
   end

endmodule
